// File: hw/rtl/acet_pkg.sv
// Shared types and constants for the ant colony edge table.
package acet_pkg;
    localparam int MaxCitiesDefault = 64;
    localparam logic [31:0] OneQ16 = 32'd65536;
    localparam logic [31:0] PherDefault = 32'd6554;
    localparam logic [16:0] DecayQ16 = 17'd62259;
    localparam logic [6:0] CityCountReset = 7'd64;
    localparam logic [15:0] EvapReset = 16'd6554;

    localparam logic [2:0] ModeLoad = 3'd0;
    localparam logic [2:0] ModeSetPher = 3'd1;
    localparam logic [2:0] ModeTour = 3'd2;
    localparam logic [2:0] ModeEvap = 3'd3;
    localparam logic [2:0] ModeJam = 3'd4;
    localparam logic [2:0] ModeReduce = 3'd5;
    localparam logic [2:0] ModeQuery = 3'd6;
    localparam logic [2:0] ModeUnused = 3'd7;

    localparam logic [0:0] RegCityCount = 1'd0;
    localparam logic [0:0] RegEvapRate = 1'd1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CLEAR   = 4'd1,  // write reset values at sweep address
        OP_CAPTURE = 4'd2,  // latch the request
        OP_RD_AB   = 4'd3,  // read entry (x,y)
        OP_WR_AB   = 4'd4,  // write/deposit/jam (x,y), then swap x,y
        OP_RD_REP  = 4'd5,  // read report entry (a,b)
        OP_REPORT  = 4'd6,  // form result
        OP_SWEEP_RD = 4'd7,
        OP_SWEEP_WR = 4'd8,
        OP_CLOSE   = 4'd9,  // set x,y to closing edge
        OP_EMPTY   = 4'd10  // form result with zero data
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_deposit;
        logic sel_jam;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       last;
        logic       tour_open;
        logic       edge_ok;
        logic       sweep_done;
        logic       clear_done;
    } t_status;
endpackage

// File: hw/rtl/acet_datapath.sv
// Table memories, sweep counter, tour registers and result formation.
module acet_datapath import acet_pkg::*; #(
    parameter int MAX_CITIES = MaxCitiesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_city_a,
    input  logic [5:0]  i_city_b,
    input  logic [31:0] i_value,
    input  logic        i_last,
    input  logic [6:0]  i_city_count,
    input  logic [15:0] i_evap_rate,
    output logic [31:0] o_eff,
    output logic [31:0] o_pher,
    output logic [23:0] o_mult,
    output logic [31:0] o_base,
    output logic        o_stat
);
    localparam int CW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int AW = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int NW = $clog2(MAX_CITIES + 1);

    logic [31:0] mem_dist [DEPTH];
    logic [23:0] mem_mult [DEPTH];
    logic [31:0] mem_pher [DEPTH];

    logic [2:0]  r_mode;
    logic [5:0]  r_a, r_b;
    logic [31:0] r_val;
    logic        r_last;
    logic [CW-1:0] r_x, r_y;
    logic        r_xy_ok;
    logic [5:0]  r_first, r_prev;
    logic        r_open;
    logic [AW:0] r_sw;
    logic [31:0] r_rd_dist, r_rd_pher;
    logic [23:0] r_rd_mult;
    logic [AW-1:0] r_sw_addr;
    logic [55:0] r_prod;
    logic [31:0] r_eff, r_pher, r_base;
    logic [23:0] r_mult;
    logic        r_stat;

    logic [NW-1:0] n_act;
    logic [AW-1:0] addr_xy, addr_rep, addr_sw;
    logic a_ok, b_ok;
    logic [32:0] dep_sum;
    logic [31:0] dep_val;
    logic [47:0] evap_prod;
    logic [40:0] dec_prod;
    logic [23:0] dec_val;
    logic [CW-1:0] sw_i, sw_j;

    function automatic logic chk(input logic [5:0] c, input logic [NW-1:0] n);
        return 32'(c) < 32'(n);
    endfunction

    always_comb begin
        if ({1'b0, i_city_count} < 8'(MAX_CITIES)) n_act = NW'(i_city_count);
        else n_act = NW'(MAX_CITIES);
        a_ok = chk(r_a, n_act);
        b_ok = chk(r_b, n_act);
        addr_xy = {r_x, r_y};
        addr_rep = {r_a[CW-1:0], r_b[CW-1:0]};
        sw_i = r_sw[AW-1:CW];
        sw_j = r_sw[CW-1:0];
        addr_sw = r_sw[AW-1:0];
        dep_sum = {1'b0, r_rd_pher} + {1'b0, r_val};
        dep_val = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
        evap_prod = r_rd_pher * (17'h10000 - {1'b0, i_evap_rate});
        dec_prod = (r_rd_mult - 24'h010000) * DecayQ16;
        dec_val = (r_rd_mult > 24'h010000) ? 24'h010000 + dec_prod[39:16] : r_rd_mult;
    end

    logic sw_in;
    assign sw_in = chk(6'(sw_i), n_act) && chk(6'(sw_j), n_act);

    assign o_status.mode = r_mode;
    assign o_status.last = r_last;
    assign o_status.tour_open = r_open;
    assign o_status.edge_ok = r_xy_ok;
    assign o_status.sweep_done = (r_sw == (AW+1)'(DEPTH - 1));
    assign o_status.clear_done = (r_sw == (AW+1)'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLEAR: begin
                mem_dist[addr_sw] <= 32'd0;
                mem_mult[addr_sw] <= 24'h010000;
                mem_pher[addr_sw] <= PherDefault;
            end
            OP_WR_AB: begin
                if (r_xy_ok) begin
                    if (i_cmd.sel_deposit) mem_pher[addr_xy] <= dep_val;
                    else if (i_cmd.sel_jam) mem_mult[addr_xy] <= r_val[23:0];
                    else if (r_mode == ModeLoad) mem_dist[addr_xy] <= r_val;
                    else mem_pher[addr_xy] <= r_val;
                end
            end
            OP_SWEEP_WR: begin
                if (sw_in) begin
                    if (r_mode == ModeEvap) mem_pher[r_sw_addr] <= evap_prod[47:16];
                    else mem_mult[r_sw_addr] <= dec_val;
                end
            end
            default: ;
        endcase
        case (i_cmd.op)
            OP_RD_AB: begin
                r_rd_pher <= mem_pher[addr_xy];
            end
            OP_RD_REP: begin
                r_rd_dist <= mem_dist[addr_rep];
                r_rd_mult <= mem_mult[addr_rep];
                r_rd_pher <= mem_pher[addr_rep];
            end
            OP_SWEEP_RD: begin
                r_rd_mult <= mem_mult[addr_sw];
                r_rd_pher <= mem_pher[addr_sw];
                r_sw_addr <= addr_sw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_first <= '0;
            r_prev  <= '0;
            r_sw    <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_sw <= r_sw + 1'b1;
                OP_CAPTURE: begin
                    r_sw <= '0;
                    if (i_mode == ModeTour) begin
                        if (!r_open) begin
                            r_first <= i_city_a;
                            r_open <= 1'b1;
                        end
                        r_prev <= i_city_a;
                        if (i_last) r_open <= 1'b0;
                    end
                end
                OP_SWEEP_WR: r_sw <= r_sw + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_mode <= i_mode;
                r_a <= i_city_a;
                r_b <= i_city_b;
                r_val <= i_value;
                r_last <= i_last;
                if (i_mode == ModeTour) begin
                    r_x <= r_prev[CW-1:0];
                    r_y <= i_city_a[CW-1:0];
                    r_xy_ok <= r_open && chk(r_prev, n_act) && chk(i_city_a, n_act);
                end else begin
                    r_x <= i_city_a[CW-1:0];
                    r_y <= i_city_b[CW-1:0];
                    r_xy_ok <= chk(i_city_a, n_act) && chk(i_city_b, n_act);
                end
            end
            OP_WR_AB: begin
                r_x <= r_y;
                r_y <= r_x;
            end
            OP_CLOSE: begin
                // closing edge is the last one of this request
                r_last <= 1'b0;
                r_x <= r_a[CW-1:0];
                r_y <= r_first[CW-1:0];
                r_xy_ok <= a_ok && chk(r_first, n_act);
            end
            default: ;
        endcase
        r_prod <= r_rd_dist * r_rd_mult;
    end

    // result register; the report takes the product of the read data from the r_prod register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_REPORT) begin
            if (a_ok && b_ok) begin
                r_eff  <= (|r_prod[55:48]) ? 32'hFFFF_FFFF : r_prod[47:16];
                r_pher <= r_rd_pher;
                r_mult <= r_rd_mult;
                r_base <= r_rd_dist;
                r_stat <= 1'b0;
            end else begin
                r_eff  <= '0;
                r_pher <= PherDefault;
                r_mult <= 24'h010000;
                r_base <= '0;
                r_stat <= 1'b1;
            end
        end else if (i_cmd.op == OP_EMPTY) begin
            r_eff <= '0;
            r_pher <= '0;
            r_mult <= '0;
            r_base <= '0;
            r_stat <= (r_mode == ModeTour) ? !a_ok : (r_mode == ModeUnused);
        end
    end

    assign o_eff = r_eff;
    assign o_pher = r_pher;
    assign o_mult = r_mult;
    assign o_base = r_base;
    assign o_stat = r_stat;
endmodule

// File: hw/rtl/acet_ctrl.sv
// Controller state machine sequencing each request.
module acet_ctrl import acet_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RD     = 12'b000000000100,
        S_WR     = 12'b000000001000,
        S_RD2    = 12'b000000010000,
        S_WR2    = 12'b000000100000,
        S_CLOSE  = 12'b000001000000,
        S_REPRD  = 12'b000010000000,
        S_REPMUL = 12'b000100000000,
        S_REP    = 12'b001000000000,
        S_SWRD   = 12'b010000000000,
        S_SWWR   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic r_close, n_close;
    logic take;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign take = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_close = r_close;
        o_cmd = '{op: OP_NONE, sel_deposit: 1'b0, sel_jam: 1'b0};
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // dispatch on captured mode
                case (i_status.mode)
                    ModeLoad, ModeSetPher: begin
                        o_cmd.op = OP_WR_AB;
                        n_state = S_REPRD;
                    end
                    ModeJam: begin
                        o_cmd.op = OP_WR_AB;
                        o_cmd.sel_jam = 1'b1;
                        n_state = S_WR2;
                    end
                    ModeTour: begin
                        o_cmd.op = OP_RD_AB;
                        n_close = i_status.last;
                        n_state = S_WR;
                    end
                    ModeEvap, ModeReduce: begin
                        o_cmd.op = OP_SWEEP_RD;
                        n_state = S_SWWR;
                    end
                    ModeQuery: n_state = S_REPRD;
                    default: begin
                        o_cmd.op = OP_EMPTY;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WR: begin
                o_cmd.op = OP_WR_AB;
                o_cmd.sel_deposit = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.op = OP_RD_AB;
                n_state = S_WR2;
            end
            S_WR2: begin
                if (i_status.mode == ModeJam) begin
                    o_cmd.op = OP_WR_AB;
                    o_cmd.sel_jam = 1'b1;
                    n_state = S_REPRD;
                end else begin
                    o_cmd.op = OP_WR_AB;
                    o_cmd.sel_deposit = 1'b1;
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (r_close) begin
                    o_cmd.op = OP_CLOSE;
                    n_close = 1'b0;
                    n_state = S_RD;
                end else begin
                    o_cmd.op = OP_EMPTY;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_REPRD: begin
                o_cmd.op = OP_RD_REP;
                n_state = S_REPMUL;
            end
            S_REPMUL: begin
                o_cmd.op = OP_NONE;
                n_state = S_REP;
            end
            S_REP: begin
                o_cmd.op = OP_REPORT;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SWRD: begin
                o_cmd.op = OP_SWEEP_RD;
                n_state = S_SWWR;
            end
            S_SWWR: begin
                o_cmd.op = OP_SWEEP_WR;
                if (i_status.sweep_done) begin
                    n_state = S_CLOSE;
                    n_close = 1'b0;
                end else begin
                    n_state = S_SWRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_close <= n_close;
        end
    end
endmodule

// File: hw/rtl/ant_colony_edge_table_core.sv
// Channel   | Dir | Contents
// s_axis    | in  | tdata {value,city_b,city_a,mode}, tlast last
// m_axis    | out | tdata {base_distance,multiplier,pheromone,effective_distance}, tuser status
// apb       | in  | city_count @0x0, evap_rate @0x4
// Each request is carried through to its result before the next is taken. A tour node
// does a read-modify-write of both directions on the single table port, and so does the
// closing edge when it closes the tour; evaporate/reduce sweep every table entry.
// After reset a clearing pass over every table entry (MAX_CITIES^2 for a power of two)
// fills the tables; no request is taken during it. Output stalls hold the result and
// block the next request.
module ant_colony_edge_table_core import acet_pkg::*; #(
    parameter int MAX_CITIES = MaxCitiesDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // mode[2:0] city_a[8:3] city_b[14:9] value[46:15]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // eff[31:0] pher[63:32] mult[87:64] base[119:88]
    output logic         m_axis_tuser,  // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [6:0]  r_city_count;
    logic [15:0] r_evap;
    t_cmd    cmd;
    t_status st;
    logic [31:0] eff, pher, base;
    logic [23:0] mult;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= CityCountReset;
            r_evap <= EvapReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == RegCityCount) r_city_count <= pwdata[6:0];
            else r_evap <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == RegEvapRate) ? {16'd0, r_evap} : {25'd0, r_city_count};

    acet_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(st), .o_cmd(cmd)
    );

    acet_datapath #(.MAX_CITIES(MAX_CITIES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(st),
        .i_mode(s_axis_tdata[2:0]), .i_city_a(s_axis_tdata[8:3]),
        .i_city_b(s_axis_tdata[14:9]), .i_value(s_axis_tdata[46:15]),
        .i_last(s_axis_tlast), .i_city_count(r_city_count), .i_evap_rate(r_evap),
        .o_eff(eff), .o_pher(pher), .o_mult(mult), .o_base(base), .o_stat(m_axis_tuser)
    );
    assign m_axis_tdata = {base, mult, pher, eff};
endmodule

// File: hw/rtl/acet_checker.sv
// Port-level checker bound to the core.
module acet_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[63:32] != 32'd0 |->
        m_axis_tdata[63:32] == 32'd6554)
        else $error("bad default pheromone");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind ant_colony_edge_table_core acet_checker u_chk (.*);
